// ----- rtl/core/ccpp_pkg.sv -----
package ccpp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int BORDER      = 100;
    localparam int DISC_R      = 2;
    localparam int DISC_N      = 2 * DISC_R + 1;
    localparam int DISC_CELLS  = DISC_N * DISC_N;
    localparam int MAX_PIXELS  = 13;

    localparam int COEF_W      = 32;
    localparam int PARAM_W     = 24;
    localparam int PROD_W      = COEF_W + PARAM_W + 1;
    localparam int SCALED_W    = PROD_W - FRAC_BITS;
    localparam int SCREEN_W    = 44;
    localparam int DIM_W       = 13;
    localparam int PIX_W       = 12;
    localparam int CNT_W       = 4;
    localparam int SQ_W        = 2 * (FRAC_BITS + 2);

    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH    = 13'd2560;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT   = 13'd1440;
    localparam logic [PARAM_W-1:0] RST_PIXELS_PER_UNIT = 24'd7364998;

    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT,
        CFG_PIXELS_PER_UNIT,
        CFG_PAN_X,
        CFG_PAN_Y
    } t_cfg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;

    // floor(prod >> FRAC_BITS) + coef, clamped to the signed 32-bit range
    function automatic t_coef horner_step(input t_prod prod, input t_coef coef);
        logic signed [COEF_W+9:0] sum;
        sum = (COEF_W+10)'($signed(prod[PROD_W-1:FRAC_BITS])) + (COEF_W+10)'(coef);
        if (sum > (COEF_W+10)'(64'sd2147483647)) begin
            return 32'sh7fffffff;
        end else if (sum < -(COEF_W+10)'(64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return sum[COEF_W-1:0];
    endfunction

endpackage

// ----- rtl/core/cubic_curve_point_plotter_top.sv -----
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_xa..i_yd, i_param_t
// out      output     o_out_valid / i_out_ready  o_pixel_x, o_pixel_y, o_last_pixel
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Eleven register stages from request to disc mask, then the emitter sends one disc pixel
// per cycle into the output register while the output is not stalled.
// A sample yields up to 13 pixels; the next is taken as its last pixel issues.
// Synchronous active-low reset clears valid bits and loads config registers with defaults.
// The pipeline moves as one; it stalls only while its last stage waits on the emitter.
module cubic_curve_point_plotter_top
    import ccpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_coef              i_xa,
    input  t_coef              i_xb,
    input  t_coef              i_xc,
    input  t_coef              i_xd,
    input  t_coef              i_ya,
    input  t_coef              i_yb,
    input  t_coef              i_yc,
    input  t_coef              i_yd,
    input  logic [PARAM_W-1:0] i_param_t,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PIX_W-1:0]   o_pixel_x,
    output logic [PIX_W-1:0]   o_pixel_y,
    output logic               o_last_pixel,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int NSTG = 11;
    localparam logic signed [SCREEN_W-1:0] BORDER_S = SCREEN_W'(BORDER);
    localparam logic signed [SCREEN_W-1:0] BORDER_Q = BORDER_S <<< FRAC_BITS;
    localparam logic [SQ_W:0] R2_Q = (SQ_W+1)'(DISC_R * DISC_R) << (2 * FRAC_BITS);

    // configuration
    logic [DIM_W-1:0]   r_cfg_w, r_cfg_h;
    logic [PARAM_W-1:0] r_cfg_scale;
    t_coef              r_pan_x, r_pan_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= RST_SCREEN_WIDTH;
            r_cfg_h     <= RST_SCREEN_HEIGHT;
            r_cfg_scale <= RST_PIXELS_PER_UNIT;
            r_pan_x     <= '0;
            r_pan_y     <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCREEN_WIDTH:    r_cfg_w     <= i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT:   r_cfg_h     <= i_cfg_data[DIM_W-1:0];
                CFG_PIXELS_PER_UNIT: r_cfg_scale <= i_cfg_data[PARAM_W-1:0];
                CFG_PAN_X:           r_pan_x     <= $signed(i_cfg_data);
                CFG_PAN_Y:           r_pan_y     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NSTG:1] r_vld;
    logic          adv;
    logic          em_take;

    assign adv        = !r_vld[NSTG] || em_take;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-1:1], i_in_valid};
        end
    end

    // stages 1..7: cubic evaluation and scaling
    logic signed [SCALED_W-1:0] scaled_x, scaled_y;

    ccpp_horner u_hx (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_a      (i_xa),
        .i_b      (i_xb),
        .i_c      (i_xc),
        .i_d      (i_xd),
        .i_t      (i_param_t),
        .i_scale  (r_cfg_scale),
        .o_scaled (scaled_x)
    );

    ccpp_horner u_hy (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_a      (i_ya),
        .i_b      (i_yb),
        .i_c      (i_yc),
        .i_d      (i_yd),
        .i_t      (i_param_t),
        .i_scale  (r_cfg_scale),
        .o_scaled (scaled_y)
    );

    // stage 8: screen mapping, y inverted
    logic signed [SCREEN_W-1:0] half_w, half_h, lim_w, lim_h;
    logic signed [SCREEN_W-1:0] r_sx8, r_sy8;

    assign half_w = $signed(SCREEN_W'(r_cfg_w)) <<< (FRAC_BITS - 1);
    assign half_h = $signed(SCREEN_W'(r_cfg_h)) <<< (FRAC_BITS - 1);
    assign lim_w  = ($signed(SCREEN_W'(r_cfg_w)) - BORDER_S) <<< FRAC_BITS;
    assign lim_h  = ($signed(SCREEN_W'(r_cfg_h)) - BORDER_S) <<< FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sx8 <= half_w - SCREEN_W'(r_pan_x) + SCREEN_W'(scaled_x);
            r_sy8 <= half_h - SCREEN_W'(r_pan_y) - SCREEN_W'(scaled_y);
        end
    end

    // stage 9: border test, disc origin and fractions
    logic                 r_pass9;
    logic [DIM_W-1:0]     r_bx9, r_by9;
    logic [FRAC_BITS-1:0] r_fx9, r_fy9;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pass9 <= (r_sx8 > BORDER_Q) && (r_sx8 < lim_w) &&
                       (r_sy8 > BORDER_Q) && (r_sy8 < lim_h);
            // inside the border the integer part fits in DIM_W bits
            r_bx9   <= r_sx8[FRAC_BITS+DIM_W-1:FRAC_BITS] - DIM_W'(DISC_R);
            r_by9   <= r_sy8[FRAC_BITS+DIM_W-1:FRAC_BITS] - DIM_W'(DISC_R);
            r_fx9   <= r_sx8[FRAC_BITS-1:0];
            r_fy9   <= r_sy8[FRAC_BITS-1:0];
        end
    end

    // stage 10: per-column and per-row squared offsets and range checks
    logic [SQ_W-1:0]   n_dx2 [DISC_N];
    logic [SQ_W-1:0]   n_dy2 [DISC_N];
    logic [DISC_N-1:0] n_col_ok, n_row_ok;
    logic [SQ_W-1:0]   r_dx2 [DISC_N];
    logic [SQ_W-1:0]   r_dy2 [DISC_N];
    logic [DISC_N-1:0] r_col_ok, r_row_ok;
    logic              r_pass10;
    logic [DIM_W-1:0]  r_bx10, r_by10;

    always_comb begin
        logic signed [FRAC_BITS+3:0]   dx, dy;
        logic signed [2*FRAC_BITS+7:0] sqx, sqy;
        logic [DIM_W-1:0]              ci, cj;
        for (int k = 0; k < DISC_N; k++) begin
            dx = (FRAC_BITS+4)'((k - DISC_R) * (1 << FRAC_BITS)) -
                 $signed({4'b0, r_fx9});
            dy = (FRAC_BITS+4)'((k - DISC_R) * (1 << FRAC_BITS)) -
                 $signed({4'b0, r_fy9});
            sqx = dx * dx;
            sqy = dy * dy;
            n_dx2[k] = sqx[SQ_W-1:0];
            n_dy2[k] = sqy[SQ_W-1:0];
            ci = r_bx9 + DIM_W'(k);
            cj = r_by9 + DIM_W'(k);
            // scan stops at the far edge when the centre sits on a grid line
            n_col_ok[k] = !ci[PIX_W] && !(k == DISC_N - 1 && r_fx9 == '0);
            n_row_ok[k] = !cj[PIX_W] && !(k == DISC_N - 1 && r_fy9 == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx2    <= n_dx2;
            r_dy2    <= n_dy2;
            r_col_ok <= n_col_ok;
            r_row_ok <= n_row_ok;
            r_pass10 <= r_pass9;
            r_bx10   <= r_bx9;
            r_by10   <= r_by9;
        end
    end

    // stage 11: disc mask, column-major bit order
    logic [DISC_CELLS-1:0] n_mask, r_mask11;
    logic [DIM_W-1:0]      r_bx11, r_by11;

    always_comb begin
        for (int a = 0; a < DISC_N; a++) begin
            for (int b = 0; b < DISC_N; b++) begin
                n_mask[a*DISC_N+b] = r_pass10 && r_col_ok[a] && r_row_ok[b] &&
                    (({1'b0, r_dx2[a]} + {1'b0, r_dy2[b]}) <= R2_Q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mask11 <= n_mask;
            r_bx11   <= r_bx10;
            r_by11   <= r_by10;
        end
    end

    // pixel emitter
    logic                  r_em_valid;
    logic [DISC_CELLS-1:0] r_em_mask;
    logic [DIM_W-1:0]      r_em_bx, r_em_by;
    logic [CNT_W-1:0]      r_em_cnt;
    logic [DISC_CELLS-1:0] sel_hot, rest;
    logic [2:0]            sel_a, sel_b;
    logic                  em_last, out_free;
    logic                  r_out_valid, r_last;
    logic [PIX_W-1:0]      r_pixel_x, r_pixel_y;
    logic [DIM_W-1:0]      px, py;

    always_comb begin
        sel_hot = '0;
        sel_a   = '0;
        sel_b   = '0;
        // lowest set bit wins
        for (int a = DISC_N - 1; a >= 0; a--) begin
            for (int b = DISC_N - 1; b >= 0; b--) begin
                if (r_em_mask[a*DISC_N+b]) begin
                    sel_hot                = '0;
                    sel_hot[a*DISC_N+b]    = 1'b1;
                    sel_a                  = 3'(a);
                    sel_b                  = 3'(b);
                end
            end
        end
    end

    assign rest     = r_em_mask & ~sel_hot;
    assign em_last  = (rest == '0) || (r_em_cnt == CNT_W'(MAX_PIXELS - 1));
    assign out_free = !r_out_valid || i_out_ready;
    assign em_take  = !r_em_valid || (out_free && em_last);
    assign px       = r_em_bx + DIM_W'(sel_a);
    assign py       = r_em_by + DIM_W'(sel_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid  <= 1'b0;
            r_em_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_em_valid;
            end
            if (em_take) begin
                r_em_valid <= r_vld[NSTG] && (r_mask11 != '0);
                r_em_cnt   <= '0;
            end else if (out_free) begin
                r_em_cnt   <= r_em_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_em_valid) begin
            r_pixel_x <= px[PIX_W-1:0];
            r_pixel_y <= py[PIX_W-1:0];
            r_last    <= em_last;
        end
        if (em_take) begin
            r_em_mask <= r_mask11;
            r_em_bx   <= r_bx11;
            r_em_by   <= r_by11;
        end else if (out_free) begin
            r_em_mask <= rest;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_last_pixel = r_last;

endmodule

// ----- rtl/core/ccpp_horner.sv -----
module ccpp_horner
    import ccpp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  t_coef                      i_a,
    input  t_coef                      i_b,
    input  t_coef                      i_c,
    input  t_coef                      i_d,
    input  logic [PARAM_W-1:0]         i_t,
    input  logic [PARAM_W-1:0]         i_scale,
    output logic signed [SCALED_W-1:0] o_scaled
);

    // three Horner steps (multiply, then shift/add/clamp), then the scale multiply
    t_prod              r_p1, r_p3, r_p5, r_m7;
    t_coef              r_b1, r_c1, r_d1, r_acc2, r_c2, r_d2, r_c3, r_d3;
    t_coef              r_acc4, r_d4, r_d5, r_g6;
    logic [PARAM_W-1:0] r_t1, r_t2, r_t3, r_t4;

    t_prod n_p1, n_p3, n_p5, n_m7;

    always_comb begin
        n_p1 = i_a * $signed({1'b0, i_t});
        n_p3 = r_acc2 * $signed({1'b0, r_t2});
        n_p5 = r_acc4 * $signed({1'b0, r_t4});
        n_m7 = r_g6 * $signed({1'b0, i_scale});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= n_p1;
            r_b1   <= i_b;
            r_c1   <= i_c;
            r_d1   <= i_d;
            r_t1   <= i_t;

            r_acc2 <= horner_step(r_p1, r_b1);
            r_c2   <= r_c1;
            r_d2   <= r_d1;
            r_t2   <= r_t1;

            r_p3   <= n_p3;
            r_c3   <= r_c2;
            r_d3   <= r_d2;
            r_t3   <= r_t2;

            r_acc4 <= horner_step(r_p3, r_c3);
            r_d4   <= r_d3;
            r_t4   <= r_t3;

            r_p5   <= n_p5;
            r_d5   <= r_d4;

            r_g6   <= horner_step(r_p5, r_d5);

            r_m7   <= n_m7;
        end
    end

    assign o_scaled = $signed(r_m7[PROD_W-1:FRAC_BITS]);

endmodule

// ----- rtl/core/ccpp_checker.sv -----
module ccpp_checker
    import ccpp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [PIX_W-1:0]   o_pixel_x,
    input logic [PIX_W-1:0]   o_pixel_y,
    input logic               o_last_pixel
);

    localparam logic [PIX_W-1:0] PIX_MIN = PIX_W'(BORDER - DISC_R);

    // output register empties and intake opens on reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or intake blocked after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y) &&
            $stable(o_last_pixel))
        else $error("stalled pixel changed");

    // a disc is emitted without gaps, columns in ascending order
    a_disc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_pixel |=>
            o_out_valid && (o_pixel_x >= $past(o_pixel_x)) &&
            ({1'b0, o_pixel_x} <=
             {1'b0, $past(o_pixel_x)} + (PIX_W+1)'(2 * DISC_R)))
        else $error("disc pixels out of order");

    // the border test keeps every pixel at least BORDER - DISC_R from the left and top edges
    a_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_x >= PIX_MIN) && (o_pixel_y >= PIX_MIN))
        else $error("pixel inside the border");

endmodule

bind cubic_curve_point_plotter_top ccpp_checker u_ccpp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_last_pixel (o_last_pixel)
);
